@@ src/saw_pkg.sv @@
// Shared types and constants for the stop-and-wait ARQ controller.
// No dependencies; used by the event logic, the result queue and the top level.
`default_nettype none
package saw_pkg;

    localparam int LEN_W   = 11;
    localparam int TICK_W  = 16;
    localparam int RETRY_W = 8;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_ACK  = 2'd1,
        OP_DATA = 2'd2,
        OP_TICK = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_TX      = 3'd1,
        ACT_RETX    = 3'd2,
        ACT_ACK     = 3'd3,
        ACT_DELIVER = 3'd4,
        ACT_BUSY    = 3'd5,
        ACT_LIMIT   = 3'd6
    } t_action;

    localparam logic [CFG_IDX_W-1:0] CFG_ARQ_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd2;

    localparam logic [TICK_W-1:0]  RETRY_TICKS_RST = 16'd100;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 8'd20;

    typedef struct packed {
        t_action          action;
        logic             seq;
        logic [LEN_W-1:0] length;
        logic             last;
    } t_result;

    // write request from the event logic into the result queue
    typedef struct packed {
        logic wr;
        logic two;
    } t_push;

endpackage
`default_nettype wire

@@ src/saw_core.sv @@
// Event logic of the ARQ controller: configuration registers, link state and
// the one or two results each event produces. Depends on saw_pkg.
`default_nettype none
module saw_core #(
    parameter logic [saw_pkg::LEN_W-1:0] LEN_CAP = 11'd1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [saw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [saw_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_accept,
    input  wire logic [1:0]                    i_operation,
    input  wire logic                          i_seq_bit,
    input  wire logic [saw_pkg::LEN_W-1:0]     i_length,
    output saw_pkg::t_push                     o_push,
    output saw_pkg::t_result                   o_res0,
    output saw_pkg::t_result                   o_res1
);

    logic                          r_arq_enable;
    logic [saw_pkg::TICK_W-1:0]    r_retry_ticks;
    logic [saw_pkg::RETRY_W-1:0]   r_retry_limit;

    logic                          r_awaiting_ack, n_awaiting_ack;
    logic                          r_send_bit, n_send_bit;
    logic                          r_expect_bit, n_expect_bit;
    logic [saw_pkg::RETRY_W-1:0]   r_retry_count, n_retry_count;
    logic [saw_pkg::TICK_W-1:0]    r_ticks_left, n_ticks_left;
    logic [saw_pkg::LEN_W-1:0]     r_pending_length, n_pending_length;

    logic [saw_pkg::LEN_W-1:0]     len_sat;
    saw_pkg::t_result              res0, res1;
    logic                          two;
    saw_pkg::t_op                  op;

    assign op      = saw_pkg::t_op'(i_operation);
    assign len_sat = (i_length > LEN_CAP) ? LEN_CAP : i_length;

    always_comb begin
        n_awaiting_ack   = r_awaiting_ack;
        n_send_bit       = r_send_bit;
        n_expect_bit     = r_expect_bit;
        n_retry_count    = r_retry_count;
        n_ticks_left     = r_ticks_left;
        n_pending_length = r_pending_length;
        res0 = '{action: saw_pkg::ACT_NONE, seq: 1'b0, length: '0, last: 1'b1};
        res1 = '{action: saw_pkg::ACT_NONE, seq: 1'b0, length: '0, last: 1'b1};
        two  = 1'b0;
        case (op)
            saw_pkg::OP_SEND: begin
                if (!r_arq_enable) begin
                    res0.action = saw_pkg::ACT_TX;
                    res0.length = len_sat;
                end else if (r_awaiting_ack) begin
                    res0.action = saw_pkg::ACT_BUSY;
                end else begin
                    n_pending_length = len_sat;
                    n_retry_count    = '0;
                    n_awaiting_ack   = 1'b1;
                    n_ticks_left     = r_retry_ticks;
                    res0.action      = saw_pkg::ACT_TX;
                    res0.seq         = r_send_bit;
                    res0.length      = len_sat;
                end
            end
            saw_pkg::OP_ACK: begin
                if (r_arq_enable && r_awaiting_ack && (i_seq_bit == r_send_bit)) begin
                    n_awaiting_ack   = 1'b0;
                    n_pending_length = '0;
                    n_retry_count    = '0;
                    n_ticks_left     = '0;
                    n_send_bit       = ~r_send_bit;
                end
            end
            saw_pkg::OP_DATA: begin
                if (!r_arq_enable) begin
                    if (len_sat != '0) begin
                        res0.action = saw_pkg::ACT_DELIVER;
                        res0.seq    = i_seq_bit;
                        res0.length = len_sat;
                    end
                end else begin
                    res0.action = saw_pkg::ACT_ACK;
                    res0.seq    = i_seq_bit;
                    if (i_seq_bit == r_expect_bit) begin
                        n_expect_bit = ~r_expect_bit;
                        if (len_sat != '0) begin
                            res0.last   = 1'b0;
                            res1.action = saw_pkg::ACT_DELIVER;
                            res1.seq    = i_seq_bit;
                            res1.length = len_sat;
                            two         = 1'b1;
                        end
                    end
                end
            end
            saw_pkg::OP_TICK: begin
                if (r_arq_enable && r_awaiting_ack) begin
                    if (r_ticks_left > saw_pkg::TICK_W'(1)) begin
                        n_ticks_left = r_ticks_left - saw_pkg::TICK_W'(1);
                    end else if (r_retry_count >= r_retry_limit) begin
                        // link declared failed; send bit survives
                        n_awaiting_ack   = 1'b0;
                        n_pending_length = '0;
                        n_retry_count    = '0;
                        n_ticks_left     = '0;
                        res0.action      = saw_pkg::ACT_LIMIT;
                    end else begin
                        n_retry_count = r_retry_count + saw_pkg::RETRY_W'(1);
                        n_ticks_left  = r_retry_ticks;
                        res0.action   = saw_pkg::ACT_RETX;
                        res0.seq      = r_send_bit;
                        res0.length   = r_pending_length;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arq_enable     <= 1'b0;
            r_retry_ticks    <= saw_pkg::RETRY_TICKS_RST;
            r_retry_limit    <= saw_pkg::RETRY_LIMIT_RST;
            r_awaiting_ack   <= 1'b0;
            r_send_bit       <= 1'b0;
            r_expect_bit     <= 1'b0;
            r_retry_count    <= '0;
            r_ticks_left     <= '0;
            r_pending_length <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                saw_pkg::CFG_ARQ_ENABLE: begin
                    // enabling or disabling restarts the link
                    r_arq_enable     <= i_cfg_data[0];
                    r_awaiting_ack   <= 1'b0;
                    r_send_bit       <= 1'b0;
                    r_expect_bit     <= 1'b0;
                    r_retry_count    <= '0;
                    r_ticks_left     <= '0;
                    r_pending_length <= '0;
                end
                saw_pkg::CFG_RETRY_TICKS: begin
                    r_retry_ticks <= i_cfg_data[saw_pkg::TICK_W-1:0];
                end
                saw_pkg::CFG_RETRY_LIMIT: begin
                    r_retry_limit <= i_cfg_data[saw_pkg::RETRY_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            r_awaiting_ack   <= n_awaiting_ack;
            r_send_bit       <= n_send_bit;
            r_expect_bit     <= n_expect_bit;
            r_retry_count    <= n_retry_count;
            r_ticks_left     <= n_ticks_left;
            r_pending_length <= n_pending_length;
        end
    end

    assign o_push.wr  = i_accept;
    assign o_push.two = two;
    assign o_res0     = res0;
    assign o_res1     = res1;

endmodule
`default_nettype wire

@@ src/saw_rqueue.sv @@
// Four-entry result queue: takes one or two results per event, hands them
// out one per transfer. Depends on saw_pkg.
`default_nettype none
module saw_rqueue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire saw_pkg::t_push   i_push,
    input  wire saw_pkg::t_result i_res0,
    input  wire saw_pkg::t_result i_res1,
    output logic                  o_space,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output saw_pkg::t_result      o_head
);

    localparam int DEPTH = 4;

    saw_pkg::t_result r_mem [DEPTH];
    logic [1:0]       r_wr_ptr, n_wr_ptr;
    logic [1:0]       r_rd_ptr, n_rd_ptr;
    logic [2:0]       r_count, n_count;
    logic             pop;
    logic [2:0]       n_in;

    assign pop     = o_valid && i_ready;
    assign n_in    = !i_push.wr ? 3'd0 : (i_push.two ? 3'd2 : 3'd1);
    assign n_wr_ptr = r_wr_ptr + n_in[1:0];
    assign n_rd_ptr = r_rd_ptr + {1'b0, pop};
    assign n_count  = r_count + n_in - {2'b00, pop};

    // room for a worst-case event, known from registered state alone
    assign o_space = (r_count <= 3'(DEPTH - 2));
    assign o_valid = (r_count != 3'd0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.wr) begin
            r_mem[r_wr_ptr] <= i_res0;
            if (i_push.two) begin
                r_mem[r_wr_ptr + 2'd1] <= i_res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

@@ src/stop_and_wait_arq.sv @@
// Stop-and-wait ARQ controller, alternating-bit. Each accepted event puts its
// results into the result queue, whose head is offered at the output. One event
// per cycle while results drain; an event with two results goes out as two
// transfers. The four-entry result queue sets the rate: an event is taken while
// at least two slots are free. Synchronous active-low reset clears link state,
// restores register defaults and empties the queue; no clearing pass.
`default_nettype none
module stop_and_wait_arq #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [saw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [saw_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_operation,
    input  wire logic                          i_seq_bit,
    input  wire logic [saw_pkg::LEN_W-1:0]     i_length,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [2:0]                         o_action,
    output logic                               o_seq_out,
    output logic [saw_pkg::LEN_W-1:0]          o_length_out,
    output logic                               o_last
);

    localparam int LEN_CAP_I = (MAX_PAYLOAD < 2047) ? MAX_PAYLOAD : 2047;
    localparam logic [saw_pkg::LEN_W-1:0] LEN_CAP = LEN_CAP_I[saw_pkg::LEN_W-1:0];

    saw_pkg::t_push   push;
    saw_pkg::t_result res0, res1, head;
    logic             space;
    logic             accept;

    assign o_ready = space;
    assign accept  = i_valid && space;

    saw_core #(
        .LEN_CAP (LEN_CAP)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_operation (i_operation),
        .i_seq_bit   (i_seq_bit),
        .i_length    (i_length),
        .o_push      (push),
        .o_res0      (res0),
        .o_res1      (res1)
    );

    saw_rqueue u_rqueue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_head  (head)
    );

    assign o_action     = head.action;
    assign o_seq_out    = head.seq;
    assign o_length_out = head.length;
    assign o_last       = head.last;

endmodule
`default_nettype wire

@@ verif/tb_stop_and_wait_arq.sv @@
// Self-checking testbench for the stop-and-wait ARQ controller: directed events, random
// protocol traffic under varied handshake idling, and a long output hold-off.
// Depends on saw_pkg and stop_and_wait_arq.
module tb_stop_and_wait_arq;
    import saw_pkg::*;

    localparam int MAX_PAYLOAD   = 1024;
    localparam int QUIET_LIMIT   = 4000;
    localparam int ITEMS_PER_RUN = 175;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic [1:0]           i_operation = '0;
    logic                 i_seq_bit   = 1'b0;
    logic [LEN_W-1:0]     i_length    = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic [2:0]           o_action;
    logic                 o_seq_out;
    logic [LEN_W-1:0]     o_length_out;
    logic                 o_last;

    stop_and_wait_arq #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_seq_bit    (i_seq_bit),
        .i_length     (i_length),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_action     (o_action),
        .o_seq_out    (o_seq_out),
        .o_length_out (o_length_out),
        .o_last       (o_last)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // handshake idling, percent of cycles
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int n_errors      = 0;

    // link model
    logic               arq_on;
    logic [TICK_W-1:0]  cfg_ticks;
    logic [RETRY_W-1:0] cfg_limit;
    logic               waiting;
    logic               tx_bit;
    logic               rx_expect_bit;
    logic [RETRY_W-1:0] retries;
    logic [TICK_W-1:0]  ticks_to_go;
    logic [LEN_W-1:0]   held_len;

    t_result due_results[$];

    function automatic void clear_link_model();
        waiting       = 1'b0;
        tx_bit        = 1'b0;
        rx_expect_bit = 1'b0;
        retries       = '0;
        ticks_to_go   = '0;
        held_len      = '0;
    endfunction

    function automatic void arq_predict(input t_op op, input logic seq,
                                        input logic [LEN_W-1:0] len);
        t_result          r0;
        t_result          r1;
        logic [LEN_W-1:0] l;
        int               n;
        l  = (len > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : len;
        r0 = '0;
        r1 = '0;
        r0.action = ACT_NONE;
        r1.action = ACT_NONE;
        n  = 1;
        case (op)
            OP_SEND: begin
                if (!arq_on) begin
                    r0.action = ACT_TX;
                    r0.length = l;
                end else if (waiting) begin
                    r0.action = ACT_BUSY;
                end else begin
                    held_len    = l;
                    retries     = '0;
                    waiting     = 1'b1;
                    ticks_to_go = cfg_ticks;
                    r0.action   = ACT_TX;
                    r0.seq      = tx_bit;
                    r0.length   = l;
                end
            end
            OP_ACK: begin
                if (arq_on && waiting && seq == tx_bit) begin
                    waiting     = 1'b0;
                    held_len    = '0;
                    retries     = '0;
                    ticks_to_go = '0;
                    tx_bit      = ~tx_bit;
                end
            end
            OP_DATA: begin
                if (!arq_on) begin
                    if (l != 0) begin
                        r0.action = ACT_DELIVER;
                        r0.seq    = seq;
                        r0.length = l;
                    end
                end else begin
                    r0.action = ACT_ACK;
                    r0.seq    = seq;
                    if (seq == rx_expect_bit) begin
                        rx_expect_bit = ~rx_expect_bit;
                        if (l != 0) begin
                            r1.action = ACT_DELIVER;
                            r1.seq    = seq;
                            r1.length = l;
                            n = 2;
                        end
                    end
                end
            end
            default: begin
                if (arq_on && waiting) begin
                    if (ticks_to_go > 1) begin
                        ticks_to_go = ticks_to_go - 1'b1;
                    end else if (retries >= cfg_limit) begin
                        waiting     = 1'b0;
                        held_len    = '0;
                        retries     = '0;
                        ticks_to_go = '0;
                        r0.action   = ACT_LIMIT;
                    end else begin
                        retries     = retries + 1'b1;
                        ticks_to_go = cfg_ticks;
                        r0.action   = ACT_RETX;
                        r0.seq      = tx_bit;
                        r0.length   = held_len;
                    end
                end
            end
        endcase
        if (n == 1) begin
            r0.last = 1'b1;
            due_results.push_back(r0);
        end else begin
            r1.last = 1'b1;
            due_results.push_back(r0);
            due_results.push_back(r1);
        end
    endfunction

    function automatic logic [LEN_W-1:0] rand_length();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return LEN_W'($urandom_range(20));
        else if (r < 75)
            return LEN_W'(MAX_PAYLOAD);
        else if (r < 85)
            return LEN_W'($urandom_range(2047, MAX_PAYLOAD + 1));
        else
            return LEN_W'($urandom_range(2047));
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_event(input t_op op, input logic seq, input logic [LEN_W-1:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_operation = op;
        i_seq_bit   = seq;
        i_length    = len;
        i_valid     = 1'b1;
        do
            @(posedge i_clk);
        while (o_ready !== 1'b1);
        arq_predict(op, seq, len);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (due_results.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_ARQ_ENABLE: begin
                arq_on = data[0];
                clear_link_model();
            end
            CFG_RETRY_TICKS: cfg_ticks = data;
            CFG_RETRY_LIMIT: cfg_limit = data[RETRY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_link(input logic en, input logic [TICK_W-1:0] ticks,
                            input logic [RETRY_W-1:0] limit);
        wait_drained();
        write_reg(CFG_RETRY_TICKS, ticks);
        write_reg(CFG_RETRY_LIMIT, CFG_W'(limit));
        write_reg(CFG_ARQ_ENABLE, CFG_W'(en));
    endtask

    // mostly well-formed: acks and data frames usually carry the bit the link wants
    task automatic send_random_event();
        int   r;
        t_op  op;
        logic seq;
        r   = $urandom_range(99);
        seq = 1'($urandom_range(1));
        if (r < 25) begin
            op = OP_SEND;
        end else if (r < 45) begin
            op = OP_ACK;
            if ($urandom_range(3) != 0)
                seq = tx_bit;
        end else if (r < 70) begin
            op = OP_DATA;
            if ($urandom_range(9) < 7)
                seq = rx_expect_bit;
        end else begin
            op = OP_TICK;
        end
        send_event(op, seq, rand_length());
    endtask

    task automatic test_passthrough();
        send_event(OP_SEND, 1'b1, 11'd0);
        send_event(OP_SEND, 1'b0, 11'd1024);
        send_event(OP_SEND, 1'b1, 11'd2047);
        send_event(OP_ACK, 1'b0, 11'd5);
        send_event(OP_DATA, 1'b1, 11'd0);
        send_event(OP_DATA, 1'b1, 11'd1024);
        send_event(OP_DATA, 1'b0, 11'd1500);
        send_event(OP_TICK, 1'b1, 11'd3);
    endtask

    task automatic test_arq_handshake();
        set_link(1'b1, 16'd3, 8'd2);
        send_event(OP_ACK, 1'b0, 11'd0);     // idle ack
        send_event(OP_TICK, 1'b0, 11'd0);    // idle tick
        send_event(OP_SEND, 1'b0, 11'd1024);
        send_event(OP_SEND, 1'b0, 11'd9);    // busy
        send_event(OP_ACK, 1'b1, 11'd0);     // wrong bit
        send_event(OP_ACK, 1'b0, 11'd0);
        send_event(OP_DATA, 1'b0, 11'd7);
        send_event(OP_DATA, 1'b0, 11'd7);    // duplicate
        send_event(OP_DATA, 1'b1, 11'd0);    // empty, still flips
        send_event(OP_DATA, 1'b0, 11'd2047); // saturated
    endtask

    task automatic test_retry_deadline();
        set_link(1'b1, 16'd2, 8'd1);
        send_event(OP_SEND, 1'b0, 11'd33);
        repeat (4) send_event(OP_TICK, 1'b0, 11'd0);
        // zero tick count: first tick is already the deadline
        set_link(1'b1, 16'd0, 8'd1);
        send_event(OP_SEND, 1'b1, 11'd4);
        send_event(OP_TICK, 1'b0, 11'd0);
        send_event(OP_TICK, 1'b0, 11'd0);
        set_link(1'b1, 16'd1, 8'd0);
        send_event(OP_SEND, 1'b0, 11'd12);
        send_event(OP_TICK, 1'b1, 11'd0);
        send_event(OP_ACK, 1'b0, 11'd0);
    endtask

    task automatic test_random_traffic();
        int k;
        for (k = 0; k < 8; k++) begin
            case (k / 2)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 78; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 78; end
                default: begin send_idle_pct = 21; stall_pct = 21; end
            endcase
            case (k)
                0: set_link(1'b1, 16'd2, 8'd1);
                1: set_link(1'b0, 16'd100, 8'd20);
                2: set_link(1'b1, 16'd1, 8'd0);
                3: set_link(1'b1, 16'd65535, 8'd255);
                4: set_link(1'b1, 16'd3, 8'd2);
                5: set_link(1'b1, 16'd0, 8'd255);
                6: set_link(1'b1, TICK_W'($urandom_range(5, 1)), RETRY_W'($urandom_range(3)));
                default: set_link(1'b1, 16'd1, 8'd3);
            endcase
            repeat (ITEMS_PER_RUN) send_random_event();
        end
    endtask

    // output held off long enough that the result queue fills and the input stalls
    task automatic test_backpressure();
        set_link(1'b1, 16'd2, 8'd2);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 300;
        repeat (40) send_random_event();
        wait_drained();
        stall_pct = 21;
        repeat (20) send_random_event();
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready = 1'b0;
            hold_left--;
        end else begin
            i_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (due_results.size() == 0) begin
                $error("result with nothing due: action %0d", o_action);
                n_errors++;
            end else begin
                want = due_results.pop_front();
                if (o_action !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, o_action);
                    n_errors++;
                end
                if (o_seq_out !== want.seq) begin
                    $error("seq_out: expected %0d, got %0d", want.seq, o_seq_out);
                    n_errors++;
                end
                if (o_length_out !== want.length) begin
                    $error("length_out: expected %0d, got %0d", want.length, o_length_out);
                    n_errors++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    n_errors++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        arq_on    = 1'b0;
        cfg_ticks = RETRY_TICKS_RST;
        cfg_limit = RETRY_LIMIT_RST;
        clear_link_model();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_passthrough();
        test_arq_handshake();
        test_retry_deadline();
        test_random_traffic();
        test_backpressure();

        wait_drained();
        repeat (5) @(negedge i_clk);
        if (n_errors == 0 && due_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
src/saw_pkg.sv
src/saw_core.sv
src/saw_rqueue.sv
src/stop_and_wait_arq.sv
verif/tb_stop_and_wait_arq.sv
